FILE: src/size_class_handle_pool_core_defines.svh
// assertion macros for the handle pool
`ifndef SIZE_CLASS_HANDLE_POOL_CORE_DEFINES_SVH
`define SIZE_CLASS_HANDLE_POOL_CORE_DEFINES_SVH
// implication checked at every rising clock edge outside reset
`define SCHP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define SCHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/schp_pkg.sv
`default_nettype none
package schp_pkg;
  localparam int NUM_CLASSES = 16;
  localparam int MAX_HANDLES = 256;
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int HW = $clog2(MAX_HANDLES);
  localparam int DW = HW + 1;
  localparam int SW = CW + HW;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ZERO = 3'd1, ST_BIG = 3'd2, ST_EXHAUST = 3'd3, ST_BADFREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC, OP_FREE, OP_ERR
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic [CW-1:0] cls;
    logic [HW-1:0] handle;
    status_t     status;
  } cmd_t;

  typedef struct packed {
    logic [HW-1:0] handle;
    logic [CW-1:0] cls;
    logic          fresh;
    status_t       status;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_READ, BK_WRITE, BK_OUT
  } bk_state_t;

  // ceil(log2(bytes)), 6 bits to hold up to 32
  function automatic logic [5:0] ceil_log2(input logic [31:0] b);
    logic [31:0] m;
    logic [5:0] r;
    m = b - 32'd1;
    r = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) r = 6'(i + 1);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/schp_front.sv
`default_nettype none
module schp_front import schp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic kind,
  input  wire logic [31:0] request_bytes,
  input  wire logic [7:0]  handle_in,
  output logic      cmd_valid,
  input  wire logic cmd_ready,
  output cmd_t      cmd
);
  cmd_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  cmd_t c;
  logic [5:0] lg;

  always_comb begin
    lg = ceil_log2(request_bytes);
    c.handle = HW'(handle_in);
    c.cls = '0;
    c.status = ST_OK;
    c.op = OP_ALLOC;
    if (kind) begin
      c.op = OP_FREE;
    end else if (request_bytes == 32'd0) begin
      c.op = OP_ERR; c.status = ST_ZERO; c.handle = '0;
    end else if (lg >= 6'(NUM_CLASSES)) begin
      c.op = OP_ERR; c.status = ST_BIG; c.handle = '0;
    end else begin
      c.cls = CW'(lg);
    end
  end

  assign in_ready = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wp] <= c;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (cmd_valid && cmd_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
    end
  end
endmodule
`default_nettype wire

FILE: src/schp_back.sv
`default_nettype none
module schp_back import schp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);
  logic [CW-1:0] class_of [MAX_HANDLES];
  logic [HW-1:0] slot_of [MAX_HANDLES];
  logic [HW-1:0] free_mem [NUM_CLASSES*MAX_HANDLES];
  logic [HW-1:0] used_mem [NUM_CLASSES*MAX_HANDLES];
  logic [MAX_HANDLES-1:0] busy;
  logic [DW-1:0] minted;
  logic [DW-1:0] fdep [NUM_CLASSES];
  logic [DW-1:0] udep [NUM_CLASSES];

  bk_state_t state, state_next;
  cmd_t cur;
  logic [CW-1:0] cls;
  logic [HW-1:0] fpop, ulast, hslot;
  logic [CW-1:0] hcls;
  res_t r, r_next;
  logic bad;
  logic from_free, alloc_ok;
  logic [HW-1:0] hnew;

  // stage one: latch command, read handle tables
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid) begin
      cur <= cmd;
      hcls <= class_of[cmd.handle];
      hslot <= slot_of[cmd.handle];
    end
  end

  assign cls = (cur.op == OP_FREE) ? hcls : cur.cls;

  // stage two: read list stores once class is known
  always_ff @(posedge clk) begin
    if (state == BK_READ) begin
      fpop <= free_mem[SW'({cls, fdep[cls][HW-1:0] - HW'(1)})];
      ulast <= used_mem[SW'({cls, udep[cls][HW-1:0] - HW'(1)})];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (cmd_valid) state_next = BK_READ;
      BK_READ:  state_next = BK_WRITE;
      BK_WRITE: state_next = BK_OUT;
      BK_OUT:   if (res_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  assign cmd_ready = (state == BK_IDLE);
  assign res_valid = (state == BK_OUT);

  assign bad = !busy[cur.handle] || udep[hcls] == '0;

  // alloc source: recycled handle first, else mint the next number
  assign from_free = (fdep[cur.cls] != '0);
  assign alloc_ok = from_free || (minted != DW'(MAX_HANDLES));
  assign hnew = from_free ? fpop : minted[HW-1:0];

  always_comb begin
    r_next.handle = cur.handle;
    r_next.cls = '0;
    r_next.fresh = 1'b0;
    r_next.status = cur.status;
    unique case (cur.op)
      OP_ERR: ;
      OP_FREE: begin
        if (bad) r_next.status = ST_BADFREE;
        else r_next.cls = hcls;
      end
      default: begin
        r_next.cls = cur.cls;
        if (alloc_ok) begin
          r_next.handle = hnew;
          r_next.fresh = !from_free;
        end else begin
          r_next.handle = '0;
          r_next.status = ST_EXHAUST;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      busy <= '0;
      minted <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        fdep[i] <= '0; udep[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == BK_WRITE) begin
        r <= r_next;
        unique case (cur.op)
          OP_ERR: ;
          OP_FREE: begin
            if (!bad) begin
              slot_of[ulast] <= hslot;
              used_mem[SW'({hcls, hslot})] <= ulast;
              udep[hcls] <= udep[hcls] - DW'(1);
              free_mem[SW'({hcls, fdep[hcls][HW-1:0]})] <= cur.handle;
              fdep[hcls] <= fdep[hcls] + DW'(1);
              busy[cur.handle] <= 1'b0;
            end
          end
          default: begin
            if (alloc_ok) begin
              if (from_free) fdep[cur.cls] <= fdep[cur.cls] - DW'(1);
              else minted <= minted + DW'(1);
              slot_of[hnew] <= udep[cur.cls][HW-1:0];
              used_mem[SW'({cur.cls, udep[cur.cls][HW-1:0]})] <= hnew;
              udep[cur.cls] <= udep[cur.cls] + DW'(1);
              class_of[hnew] <= cur.cls;
              busy[hnew] <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign res = r;
endmodule
`default_nettype wire

FILE: src/size_class_handle_pool_core.sv
// size-class handle pool: allocates and frees buffer handles
// channels: s_axis carries one request per beat, m_axis one result per beat
// tuser in carries kind (0 alloc, 1 free)
// s_axis tdata: request_bytes [31:0], handle_in [39:32]
// m_axis tdata: handle_out [7:0], size_class [11:8], fresh [12], status [15:13]
// a front stage classifies requests (size rounding, range checks) into a
// two-entry queue; the back stage runs the table and stack updates
// the back stage takes a new command only after its result is taken; it runs
// each through read, read, write and output steps on the shared handle and
// list memories
// reset: synchronous rst empties all stacks and lists and the handle count;
// handle tables start undefined and are only read where written
// when m_axis_tready is low the back stage holds its result and the
// queue fills, then s_axis_tready drops
`default_nettype none
module size_class_handle_pool_core import schp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // request_bytes, handle_in
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // handle_out, size_class, fresh, status
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  // classification front end with small command queue
  schp_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .kind(s_axis_tuser), .request_bytes(s_axis_tdata[31:0]),
    .handle_in(s_axis_tdata[39:32]),
    .cmd_valid, .cmd_ready, .cmd
  );

  // table and stack engine
  schp_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {res.status, res.fresh, 4'(res.cls), 8'(res.handle)};
endmodule
`default_nettype wire

FILE: src/schp_checker.sv
`default_nettype none
`include "size_class_handle_pool_core_defines.svh"
module schp_checker import schp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  logic [2:0] out_status;
  logic       out_size_err;

  assign out_status = m_axis_tdata[15:13];
  assign out_size_err = (out_status == ST_ZERO) || (out_status == ST_BIG);

  `SCHP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SCHP_ASSERT_IMPL(a_status, m_axis_tvalid, out_status <= ST_BADFREE)
  `SCHP_ASSERT_IMPL(a_fresh_ok, m_axis_tvalid && m_axis_tdata[12], out_status == ST_OK)
  `SCHP_ASSERT_IMPL(a_err_zero, m_axis_tvalid && out_size_err, m_axis_tdata[11:0] == 12'd0)
endmodule
bind size_class_handle_pool_core schp_checker u_chk (.*);
`default_nettype wire
